// File: hw/rtl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

	localparam int TOL_BITS        = 16;
	localparam int COORD_BITS_DEF  = 24;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int OUT_TDATA_W     = 8;
	localparam logic [1:0] COUNT_SAT = 2'd3;

	typedef enum logic [1:0] {
		VERDICT_OUTSIDE  = 2'd0,
		VERDICT_INSIDE   = 2'd1,
		VERDICT_BOUNDARY = 2'd2,
		VERDICT_FEW      = 2'd3
	} verdict_t;

	// Control that travels beside an item through the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic few;       // polygon closes with fewer than three vertices
		logic e1;        // edge from this vertex back to the previous one is real
		logic e2;        // closing edge is evaluated with this item
	} ctl_t;

	// Per-edge results after the final edge stage.
	typedef struct packed {
		logic on_seg;    // query point lies on the edge
		logic crossing;  // the ray from the query point crosses the edge
		logic a_close;   // query point coincides with endpoint A
	} edge_flags_t;

endpackage

// File: hw/rtl/pip_edge.sv
`timescale 1ns / 1ps

// One edge A-B against the query point P. Four registered stages:
// differences and compares, products, sums, final flags.
module pip_edge #(
	parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pip_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [pip_pkg::TOL_BITS-1:0]       tol,
	input  logic signed [COORD_BITS-1:0]       ax,
	input  logic signed [COORD_BITS-1:0]       ay,
	input  logic signed [COORD_BITS-1:0]       bx,
	input  logic signed [COORD_BITS-1:0]       by,
	input  logic signed [COORD_BITS-1:0]       px,
	input  logic signed [COORD_BITS-1:0]       py,
	output pip_pkg::edge_flags_t               flags
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = (2 * COORD_BITS + 3 > 64) ? 64 : 2 * COORD_BITS + 3;
	localparam int MW = (DW > pip_pkg::TOL_BITS) ? DW : pip_pkg::TOL_BITS;
	localparam int TW = pip_pkg::TOL_BITS + FRAC_BITS;
	localparam int CW = (PW >= TW + 1) ? PW : TW + 1;

	typedef struct packed {
		logic c_ab_x, c_ab_y, c_pa_x, c_pa_y, c_pb_x, c_pb_y;
		logic lt_xa, lt_xb, gt_xa, gt_xb;
		logic lt_ya, lt_yb, gt_ya, gt_yb;
		logic den_pos;
	} cmp_t;

	function automatic logic close_f(input logic signed [DW-1:0] d,
	                                 input logic [pip_pkg::TOL_BITS-1:0] t);
		logic [DW-1:0] m;
		m = d[DW-1] ? DW'(-d) : DW'(d);
		return MW'(m) < MW'(t);
	endfunction

	// Stage 2: coordinate differences and compares.
	logic signed [DW-1:0] dxb, dyb, dxp, dyp, dxq, dyq;
	cmp_t                 cmp_c;

	assign dxb = DW'(bx) - DW'(ax);
	assign dyb = DW'(by) - DW'(ay);
	assign dxp = DW'(px) - DW'(ax);
	assign dyp = DW'(py) - DW'(ay);
	assign dxq = DW'(px) - DW'(bx);
	assign dyq = DW'(py) - DW'(by);

	always_comb begin
		cmp_c.c_ab_x  = close_f(dxb, tol);
		cmp_c.c_ab_y  = close_f(dyb, tol);
		cmp_c.c_pa_x  = close_f(dxp, tol);
		cmp_c.c_pa_y  = close_f(dyp, tol);
		cmp_c.c_pb_x  = close_f(dxq, tol);
		cmp_c.c_pb_y  = close_f(dyq, tol);
		cmp_c.lt_xa   = px < ax;
		cmp_c.lt_xb   = px < bx;
		cmp_c.gt_xa   = px > ax;
		cmp_c.gt_xb   = px > bx;
		cmp_c.lt_ya   = py < ay;
		cmp_c.lt_yb   = py < by;
		cmp_c.gt_ya   = py > ay;
		cmp_c.gt_yb   = py > by;
		cmp_c.den_pos = !dyb[DW-1] && (dyb != '0);
	end

	logic signed [DW-1:0] dxb_s2, dyb_s2, dxp_s2, dyp_s2;
	cmp_t                 cmp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dxb_s2 <= dxb;
			dyb_s2 <= dyb;
			dxp_s2 <= dxp;
			dyp_s2 <= dyp;
			cmp_s2 <= cmp_c;
		end
	end

	// Stage 3: six products. The cross product terms double as the ray test
	// operands: (Bx-Ax)(Py-Ay) on one side, (Px-Ax)(By-Ay) on the other.
	logic signed [2*DW-1:0] m_cr1, m_cr2, m_dt1, m_dt2, m_l1, m_l2;
	logic signed [PW-1:0]   cr1_s3, cr2_s3, dt1_s3, dt2_s3, l1_s3, l2_s3;
	cmp_t                   cmp_s3;

	assign m_cr1 = dyp_s2 * dxb_s2;
	assign m_cr2 = dxp_s2 * dyb_s2;
	assign m_dt1 = dxp_s2 * dxb_s2;
	assign m_dt2 = dyp_s2 * dyb_s2;
	assign m_l1  = dxb_s2 * dxb_s2;
	assign m_l2  = dyb_s2 * dyb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cr1_s3 <= PW'(m_cr1);
			cr2_s3 <= PW'(m_cr2);
			dt1_s3 <= PW'(m_dt1);
			dt2_s3 <= PW'(m_dt2);
			l1_s3  <= PW'(m_l1);
			l2_s3  <= PW'(m_l2);
			cmp_s3 <= cmp_s2;
		end
	end

	// Stage 4: cross, dot and squared length; ray side compare.
	logic signed [PW-1:0] cr_s4, dt_s4, len_s4;
	logic                 lhs_lt_s4, lhs_gt_s4;
	cmp_t                 cmp_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s4     <= cr1_s3 - cr2_s3;
			dt_s4     <= dt1_s3 + dt2_s3;
			len_s4    <= l1_s3 + l2_s3;
			lhs_lt_s4 <= cr2_s3 < cr1_s3;
			lhs_gt_s4 <= cr2_s3 > cr1_s3;
			cmp_s4    <= cmp_s3;
		end
	end

	// Stage 5: tolerance at product scale, then the final decisions.
	logic [CW-1:0]        tp_u;
	logic signed [CW-1:0] tp, tn, crx, dtx, dmx;
	logic signed [PW-1:0] dm;
	logic                 cr_far, dt_bad, len_bad, between_x, between_y, out_box;
	logic                 on_c, cross_c;

	assign tp_u = CW'(tol) << FRAC_BITS;
	assign tp   = $signed(tp_u);
	assign tn   = -tp;
	assign dm   = dt_s4 - len_s4;
	assign crx  = CW'(cr_s4);
	assign dtx  = CW'(dt_s4);
	assign dmx  = CW'(dm);

	always_comb begin
		cr_far    = (crx > tp) || (crx < tn);
		dt_bad    = dt_s4[PW-1] || ((dtx > tn) && (dtx < tp));
		len_bad   = (dt_s4 > len_s4) || ((dmx > tn) && (dmx < tp));
		between_x = (cmp_s4.lt_xb || cmp_s4.lt_xa) && (cmp_s4.gt_xb || cmp_s4.gt_xa);
		between_y = (cmp_s4.lt_yb || cmp_s4.lt_ya) && (cmp_s4.gt_yb || cmp_s4.gt_ya);
		out_box   = (cmp_s4.lt_xa && cmp_s4.lt_xb) || (cmp_s4.gt_xa && cmp_s4.gt_xb) ||
		            (cmp_s4.lt_ya && cmp_s4.lt_yb) || (cmp_s4.gt_ya && cmp_s4.gt_yb);

		if (cmp_s4.c_ab_x && cmp_s4.c_pa_x) begin
			on_c = !cmp_s4.c_pb_y && !cmp_s4.c_pa_y && between_y;
		end else if (cmp_s4.c_ab_y && cmp_s4.c_pa_y) begin
			on_c = !cmp_s4.c_pb_x && !cmp_s4.c_pa_x && between_x;
		end else if (out_box) begin
			on_c = 1'b0;
		end else if ((cmp_s4.c_pa_x && cmp_s4.c_pa_y) ||
		             (cmp_s4.c_pb_x && cmp_s4.c_pb_y)) begin
			on_c = 1'b0;
		end else begin
			on_c = !cr_far && !dt_bad && !len_bad;
		end

		cross_c = !(cmp_s4.c_ab_x && cmp_s4.c_ab_y) &&
		          (cmp_s4.lt_ya != cmp_s4.lt_yb) &&
		          (cmp_s4.den_pos ? lhs_lt_s4 : lhs_gt_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags.on_seg   <= on_c;
			flags.crossing <= cross_c;
			flags.a_close  <= cmp_s4.c_pa_x && cmp_s4.c_pa_y;
		end
	end

endmodule

// File: hw/rtl/point_in_polygon_test.sv
// Ray-casting point-in-polygon test. Vertices of a polygon stream in one item
// per cycle in signed fixed point (COORD_BITS wide, FRAC_BITS fraction bits);
// the first item of a polygon also carries the query point, and the item with
// tlast set closes the polygon. For that item one verdict comes out on m_tdata:
// outside, inside, on a vertex or edge, or fewer than three vertices. The
// block takes one item every cycle while its input is not held off; a verdict
// comes out once the closing item has passed an input register, the edge
// stages (differences, products, sums, decisions) and the result register.
// Both the edge back to the previous vertex and the closing edge run in
// parallel copies of the edge pipeline, so the closing vertex needs no second
// pass. Input is held off only while a new verdict is ready and the one before
// it still waits in the result register. The tolerance register (coordinate
// LSBs, reset 1, zero means nothing counts as close) is written through
// cfg_we/cfg_wdata and must only change while no polygon is in flight.
`timescale 1ns / 1ps

module point_in_polygon_test #(
	parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pip_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [pip_pkg::TOL_BITS-1:0]             cfg_wdata,    // tolerance
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// vertex_x, vertex_y, query_x, query_y from bit 0 up, zero padded
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_tdata,
	input  logic                                     s_tlast,      // last_vertex
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [pip_pkg::OUT_TDATA_W-1:0]          m_tdata       // verdict, zero padded
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// Tolerance register.
	logic [pip_pkg::TOL_BITS-1:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= pip_pkg::TOL_BITS'(1);
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Pipeline advance. Every stage moves together; the only reason to hold is
	// a closing item at the end of the pipe while the result register is full and not being taken.
	pip_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic          en, accept;
	logic          m_tvalid_q;

	assign en       = !(ctl_s5.valid && ctl_s5.last && m_tvalid_q && !m_tready);
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	coord_t in_vx, in_vy, in_qx, in_qy;

	assign in_vx = s_tdata[COORD_BITS-1:0];
	assign in_vy = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_qx = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign in_qy = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

	// Polygon front state: query point, first and previous vertex, and the
	// vertex count, which saturates at three since only "three or more" matters.
	coord_t     held_qx_q, held_qy_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [1:0] count_q;
	logic       is_first;
	coord_t     sel_qx, sel_qy, sel_fx, sel_fy;

	assign is_first = (count_q == 2'd0);
	assign sel_qx   = is_first ? in_qx : held_qx_q;
	assign sel_qy   = is_first ? in_qy : held_qy_q;
	assign sel_fx   = is_first ? in_vx : first_x_q;
	assign sel_fy   = is_first ? in_vy : first_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			if (s_tlast) begin
				count_q <= 2'd0;
			end else if (count_q != pip_pkg::COUNT_SAT) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_qx_q <= sel_qx;
			held_qy_q <= sel_qy;
			first_x_q <= sel_fx;
			first_y_q <= sel_fy;
			prev_x_q  <= in_vx;
			prev_y_q  <= in_vy;
		end
	end

	// Stage 1: the operands of both edges of this item.
	coord_t vx_s1, vy_s1, qx_s1, qy_s1, px_s1, py_s1, fx_s1, fy_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_s1 <= in_vx;
			vy_s1 <= in_vy;
			qx_s1 <= sel_qx;
			qy_s1 <= sel_qy;
			px_s1 <= prev_x_q;
			py_s1 <= prev_y_q;
			fx_s1 <= sel_fx;
			fy_s1 <= sel_fy;
		end
	end

	// After this item the count reaches three exactly when it was two or more.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1.valid <= s_tvalid;
			ctl_s1.last  <= s_tlast;
			ctl_s1.few   <= count_q < (pip_pkg::COUNT_SAT - 2'd1);
			ctl_s1.e1    <= !is_first;
			ctl_s1.e2    <= s_tlast && (count_q >= (pip_pkg::COUNT_SAT - 2'd1));
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
			ctl_s4       <= ctl_s3;
			ctl_s5       <= ctl_s4;
		end
	end

	// Edge from this vertex back to the previous one; its endpoint-A flag is
	// also the vertex-on-query test.
	pip_pkg::edge_flags_t ef_prev, ef_close;

	pip_edge #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_edge_prev (
		.clk   (clk),
		.en    (en),
		.tol   (tol_q),
		.ax    (vx_s1),
		.ay    (vy_s1),
		.bx    (px_s1),
		.by    (py_s1),
		.px    (qx_s1),
		.py    (qy_s1),
		.flags (ef_prev)
	);

	// Closing edge from the first vertex to this one, used on the last item.
	pip_edge #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_edge_close (
		.clk   (clk),
		.en    (en),
		.tol   (tol_q),
		.ax    (fx_s1),
		.ay    (fy_s1),
		.bx    (vx_s1),
		.by    (vy_s1),
		.px    (qx_s1),
		.py    (qy_s1),
		.flags (ef_close)
	);

	// Accumulate parity and boundary, and form the verdict on the last item.
	logic              parity_q, boundary_q;
	logic              parity_new, boundary_new;
	pip_pkg::verdict_t verdict_c, verdict_q;

	assign boundary_new = boundary_q || ef_prev.a_close ||
	                      (ctl_s5.e1 && ef_prev.on_seg) || (ctl_s5.e2 && ef_close.on_seg);
	assign parity_new   = parity_q ^ (ctl_s5.e1 && ef_prev.crossing) ^
	                      (ctl_s5.e2 && ef_close.crossing);

	always_comb begin
		if (ctl_s5.few) begin
			verdict_c = pip_pkg::VERDICT_FEW;
		end else if (boundary_new) begin
			verdict_c = pip_pkg::VERDICT_BOUNDARY;
		end else if (parity_new) begin
			verdict_c = pip_pkg::VERDICT_INSIDE;
		end else begin
			verdict_c = pip_pkg::VERDICT_OUTSIDE;
		end
	end

	// A new verdict loads the result register; otherwise a taken one leaves it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q   <= 1'b0;
			boundary_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (en && ctl_s5.valid) begin
				if (ctl_s5.last) begin
					parity_q   <= 1'b0;
					boundary_q <= 1'b0;
				end else begin
					parity_q   <= parity_new;
					boundary_q <= boundary_new;
				end
			end
			if (en && ctl_s5.valid && ctl_s5.last) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s5.valid && ctl_s5.last) begin
			verdict_q <= verdict_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pip_pkg::OUT_TDATA_W'(verdict_q);

endmodule

// File: hw/rtl/pip_checker.sv
`timescale 1ns / 1ps

module pip_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [pip_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	// A verdict that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed or dropped while stalled");

	// Input is held off only by a verdict waiting at the output.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// The verdict occupies two bits; the rest of the byte is padding.
	a_out_padding: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[pip_pkg::OUT_TDATA_W-1:2] == '0)
		else $error("verdict padding bits not zero");

	// A new verdict is traced back to an accepted closing item, allowing for
	// an earlier verdict or an input stall in between.
	a_no_early_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 6) ||
			$past(m_tvalid, 1) || $past(m_tvalid, 2) || $past(m_tvalid, 3) ||
			$past(m_tvalid, 4) || $past(m_tvalid, 5) || $past(m_tvalid, 6) ||
			$past(!s_tready, 1) || $past(!s_tready, 2) || $past(!s_tready, 3) ||
			$past(!s_tready, 4) || $past(!s_tready, 5))
		else $error("verdict without a closing item six cycles earlier");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CB           = pip_pkg::COORD_BITS_DEF;
	localparam int FB           = pip_pkg::FRAC_BITS_DEF;
	localparam int TDATA_W      = ((4*CB+7)/8)*8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 150;
	localparam int PHASE_ITEMS  = 70;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
	} pt_t;

	// Tracks the polygon state of the block, predicts each verdict and checks
	// the verdicts that come out in order.
	class verdict_scoreboard;
		longint            tol_c;
		longint            hqx, hqy, fx, fy, ppx, ppy;
		bit                parity, touched;
		int unsigned       count;
		pip_pkg::verdict_t verdicts[$];
		int unsigned       errors, checked;
		int unsigned       seen[4];

		function new();
			tol_c = 1;
			hqx = 0; hqy = 0; fx = 0; fy = 0; ppx = 0; ppy = 0;
			parity = 0; touched = 0; count = 0;
			errors = 0; checked = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		function bit near(longint a, longint b);
			longint d;
			d = a - b;
			if (d < 0) d = -d;
			return d < tol_c;
		endfunction

		// Same closeness, but with the tolerance scaled up to product size.
		function bit near_p(longint a, longint b);
			longint d;
			d = a - b;
			if (d < 0) d = -d;
			return d < (tol_c <<< FB);
		endfunction

		function bit on_edge(longint ax, longint ay, longint bx, longint by,
				longint px, longint py);
			longint cr, dt, l2;
			// Vertical edge with the point on its line.
			if (near(ax, bx) && near(px, ax))
				return !near(py, by) && !near(py, ay) &&
					py < ((by > ay) ? by : ay) && py > ((by < ay) ? by : ay);
			// Horizontal edge with the point on its line.
			if (near(ay, by) && near(py, ay))
				return !near(px, bx) && !near(px, ax) &&
					px < ((bx > ax) ? bx : ax) && px > ((bx < ax) ? bx : ax);
			if ((px < ax && px < bx) || (px > ax && px > bx) ||
					(py < ay && py < by) || (py > ay && py > by))
				return 0;
			// Endpoints are caught by the vertex test, not here.
			if ((near(px, ax) && near(py, ay)) || (near(px, bx) && near(py, by)))
				return 0;
			cr = (py - ay) * (bx - ax) - (px - ax) * (by - ay);
			if (cr < 0) cr = -cr;
			if (cr > (tol_c <<< FB))
				return 0;
			dt = (px - ax) * (bx - ax) + (py - ay) * (by - ay);
			if (dt < 0 || near_p(dt, 0))
				return 0;
			l2 = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
			if (dt > l2 || near_p(dt, l2))
				return 0;
			return 1;
		endfunction

		function void edge_step(longint ax, longint ay, longint bx, longint by);
			longint den, num, lhs;
			bit hit;
			if (on_edge(ax, ay, bx, by, hqx, hqy))
				touched = 1;
			if (near(ax, bx) && near(ay, by))
				return;
			if ((ay > hqy) != (by > hqy)) begin
				// Ray test without division: multiply through by the edge height
				// and flip the comparison when that height is negative.
				den = by - ay;
				num = (bx - ax) * (hqy - ay);
				lhs = (hqx - ax) * den;
				hit = (den > 0) ? (lhs < num) : (lhs > num);
				if (hit)
					parity ^= 1'b1;
			end
		endfunction

		function void note_vertex(pt_t v, pt_t q, bit last);
			longint vx, vy;
			pip_pkg::verdict_t want;
			vx = longint'(v.x);
			vy = longint'(v.y);
			if (count == 0) begin
				hqx = longint'(q.x);
				hqy = longint'(q.y);
				fx = vx;
				fy = vy;
			end
			if (near(vx, hqx) && near(vy, hqy))
				touched = 1;
			if (count != 0)
				edge_step(vx, vy, ppx, ppy);
			ppx = vx;
			ppy = vy;
			if (count < 3)
				count++;
			if (!last)
				return;
			if (count < 3) begin
				want = pip_pkg::VERDICT_FEW;
			end else begin
				edge_step(fx, fy, vx, vy);
				want = touched ? pip_pkg::VERDICT_BOUNDARY :
					(parity ? pip_pkg::VERDICT_INSIDE : pip_pkg::VERDICT_OUTSIDE);
			end
			verdicts.insert(verdicts.size(), want);
			count = 0;
			parity = 0;
			touched = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task check_verdict(logic [1:0] got);
			pip_pkg::verdict_t want;
			if (verdicts.size() == 0) begin
				report($sformatf("verdict %0d arrived with none expected", got));
				return;
			end
			want = verdicts[0];
			verdicts.delete(0);
			checked++;
			seen[int'(want)]++;
			if (got !== want)
				report($sformatf("polygon %0d: verdict %0d, expected %0d", checked, got,
					want));
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pip_pkg::TOL_BITS-1:0]    cfg_wdata;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [TDATA_W-1:0]              s_tdata;
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [pip_pkg::OUT_TDATA_W-1:0] m_tdata;

	verdict_scoreboard sb;
	pt_t         ring[$];
	pt_t         probe;
	bit          sender_gaps;
	bit          receiver_gaps;
	bit          hold_request;
	int unsigned vertices_sent;
	int unsigned tol_settings;
	int unsigned cycle_count;

	point_in_polygon_test DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic pt_t to_pt(longint x, longint y);
		pt_t p;
		p.x = x[CB-1:0];
		p.y = y[CB-1:0];
		return p;
	endfunction

	function automatic pt_t rand_pt();
		logic [31:0] rx, ry;
		rx = $urandom();
		ry = $urandom();
		return to_pt(longint'(rx), longint'(ry));
	endfunction

	// Uniform offset in [-span, span].
	function automatic longint spread(longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	// Random polygon, mostly around a random center. Grid polygons repeat
	// coordinates often, which gives degenerate, horizontal and vertical edges;
	// the query lands near the center, on a vertex, on an edge midpoint, level
	// with a vertex, just beside a vertex, or anywhere.
	function automatic void build_polygon();
		int     n, pick, k;
		bit     grid;
		longint cx, cy, span, step;
		pt_t    a, b;
		ring.delete();
		pick = $urandom_range(0, 99);
		if (pick < 8)
			n = $urandom_range(1, 2);
		else if (pick < 90)
			n = $urandom_range(3, 7);
		else
			n = $urandom_range(8, 16);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			for (k = 0; k < n; k++)
				ring.insert(ring.size(), rand_pt());
			probe = rand_pt();
			return;
		end
		grid = (pick <= 3);
		a = rand_pt();
		cx = longint'(a.x);
		cy = longint'(a.y);
		step = longint'(1) << $urandom_range(0, 12);
		span = grid ? 3 * step : (longint'(1) << $urandom_range(3, 21));
		for (k = 0; k < n; k++) begin
			if (grid)
				ring.insert(ring.size(),
					to_pt(cx + step * (longint'($urandom_range(0, 6)) - 3),
					cy + step * (longint'($urandom_range(0, 6)) - 3)));
			else
				ring.insert(ring.size(), to_pt(cx + spread(span), cy + spread(span)));
		end
		k = $urandom_range(0, n - 1);
		a = ring[k];
		b = ring[(k + 1) % n];
		pick = $urandom_range(0, 99);
		if (pick < 25)
			probe = to_pt(cx + spread(span), cy + spread(span));
		else if (pick < 45)
			probe = a;
		else if (pick < 65)
			probe = to_pt((longint'(a.x) + longint'(b.x)) >>> 1,
				(longint'(a.y) + longint'(b.y)) >>> 1);
		else if (pick < 80)
			probe = to_pt(cx + spread(span), longint'(a.y));
		else if (pick < 90)
			probe = to_pt(longint'(a.x) + spread(longint'(1) << $urandom_range(0, 16)),
				longint'(a.y) + spread(longint'(1) << $urandom_range(0, 16)));
		else
			probe = rand_pt();
	endfunction

	function automatic void add_vertex(longint x, longint y);
		ring.insert(ring.size(), to_pt(x, y));
	endfunction

	task automatic send_vertex(pt_t v, pt_t q, bit last);
		logic [TDATA_W-1:0] word;
		int gap;
		word = '0;
		word[0 +: CB]    = v.x;
		word[CB +: CB]   = v.y;
		word[2*CB +: CB] = q.x;
		word[3*CB +: CB] = q.y;
		gap = sender_gaps ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_vertex(v, q, last);
		vertices_sent++;
	endtask

	// The query only matters on the first vertex; later vertices carry the
	// same query or junk, which the block must ignore.
	task automatic send_ring();
		int k;
		for (k = 0; k < ring.size(); k++)
			send_vertex(ring[k], (k == 0 || $urandom_range(0, 1)) ? probe : rand_pt(),
				k == ring.size() - 1);
	endtask

	// Drop valid, then let every outstanding verdict come back.
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [pip_pkg::TOL_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.tol_c = longint'(value);
		tol_settings++;
	endtask

	task automatic run_directed();
		// One vertex at the coordinate extremes, then two vertices, each time with the query on a vertex: still too few.
		ring.delete(); add_vertex(-8388608, 8388607);
		probe = to_pt(-8388608, 8388607); send_ring();
		ring.delete(); add_vertex(8388607, -8388608); add_vertex(0, 0);
		probe = to_pt(0, 0); send_ring();
		// Square, query inside and then outside.
		ring.delete();
		add_vertex(0, 0); add_vertex(2560, 0); add_vertex(2560, 2560); add_vertex(0, 2560);
		probe = to_pt(1280, 1280); send_ring();
		probe = to_pt(3840, 1280); send_ring();
		// Query on a vertex, then on a horizontal edge.
		ring.delete(); add_vertex(0, 0); add_vertex(2560, 0); add_vertex(0, 2560);
		probe = to_pt(2560, 0); send_ring();
		probe = to_pt(1280, 0); send_ring();
		// Repeated vertex gives a degenerate edge.
		ring.delete();
		add_vertex(0, 0); add_vertex(0, 0); add_vertex(2560, 0); add_vertex(0, 2560);
		probe = to_pt(512, 512); send_ring();
		// Triangle spanning the whole coordinate range.
		ring.delete();
		add_vertex(-8388608, -8388608); add_vertex(8388607, -8388608); add_vertex(0, 8388607);
		probe = to_pt(0, 0); send_ring();
	endtask

	// One-vertex polygons at full rate while the receiver holds off, so the
	// verdict buffer fills and the block stalls its input.
	task automatic run_backpressure();
		hold_request = 1'b1;
		sender_gaps = 1'b0;
		repeat (24) begin
			ring.delete();
			ring.insert(ring.size(), rand_pt());
			probe = rand_pt();
			send_ring();
		end
		sender_gaps = 1'b1;
		wait_drain();
	endtask

	// Receiver: random hold-off before each verdict, one long hold on request.
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = receiver_gaps ? $urandom_range(0, 3) : 0;
			if (hold_request) begin
				gap = LONG_HOLD;
				hold_request = 1'b0;
			end
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_verdict(m_tdata[1:0]);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d verdicts outstanding", cycle_count,
			sb.pending());
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int                           ph;
		int unsigned                  target;
		bit                           paused;
		logic [pip_pkg::TOL_BITS-1:0] tol;
		sb = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		hold_request  = 1'b0;
		vertices_sent = 0;
		tol_settings  = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset tolerance of one LSB: exact equality.
		run_directed();
		wait_drain();

		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: tol = '0;
				1: tol = 16'hFFFF;
				2: tol = 16'd1;
				3: tol = 16'd16;
				4: tol = 16'($urandom_range(2, 300));
				5: tol = 16'($urandom_range(1, 65535));
				default: tol = 16'd256;
			endcase
			write_tolerance(tol);
			sender_gaps   = (ph != 3);
			receiver_gaps = (ph != 3);
			if (ph == 2)
				run_backpressure();
			target = vertices_sent + PHASE_ITEMS;
			paused = 1'b0;
			while (vertices_sent < target) begin
				build_polygon();
				send_ring();
				// Midway the sender stops until every verdict is back.
				if (!paused && vertices_sent + PHASE_ITEMS / 2 >= target) begin
					wait_drain();
					paused = 1'b1;
				end
			end
			wait_drain();
		end

		$display("Covered %0d vertices in %0d polygons under %0d tolerance settings,",
			vertices_sent, sb.checked, tol_settings);
		$display("with a long output stall and a full-rate stretch; verdicts %0d/%0d/%0d/%0d",
			sb.seen[pip_pkg::VERDICT_OUTSIDE], sb.seen[pip_pkg::VERDICT_INSIDE],
			sb.seen[pip_pkg::VERDICT_BOUNDARY], sb.seen[pip_pkg::VERDICT_FEW]);
		if (sb.errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
